>>> design/u16esc_pkg.sv
// Shared types, constants and byte helpers of the UTF-16 to escaped UTF-8 transcoder.
package u16esc_pkg;

  // Default depth of the queue between the classifier and the byte sequencer.
  localparam int unsigned QUEUE_DEPTH = 4;

  // UTF-16 surrogate ranges.
  localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPP_PLANE_BASE = 21'h10000;

  // Control code boundaries.
  localparam logic [15:0] CTRL_LIMIT = 16'h0020;
  localparam logic [15:0] CODE_DEL   = 16'h007F;
  localparam logic [15:0] ONE_BYTE_MAX = 16'h007F;
  localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;

  // Characters with a short escape, and the escape letters.
  localparam logic [15:0] CODE_BSLASH = 16'h005C;
  localparam logic [15:0] CODE_QUOTE  = 16'h0022;
  localparam logic [15:0] CODE_LF     = 16'h000A;
  localparam logic [15:0] CODE_CR     = 16'h000D;
  localparam logic [15:0] CODE_TAB    = 16'h0009;
  localparam logic [7:0]  CHR_BSLASH  = 8'h5C;
  localparam logic [7:0]  CHR_QUOTE   = 8'h22;
  localparam logic [7:0]  CHR_N       = 8'h6E;
  localparam logic [7:0]  CHR_R       = 8'h72;
  localparam logic [7:0]  CHR_T       = 8'h74;
  localparam logic [7:0]  CHR_U       = 8'h75;
  localparam logic [7:0]  CHR_ZERO    = 8'h30;
  localparam logic [7:0]  CHR_UPPER_A = 8'h41;

  // UTF-8 lead and continuation marks.
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  // Replacement character U+FFFD as UTF-8.
  localparam logic [7:0] REPL_BYTE0 = 8'hEF;
  localparam logic [7:0] REPL_BYTE1 = 8'hBF;
  localparam logic [7:0] REPL_BYTE2 = 8'hBD;
  localparam logic [3:0] REPL_LEN   = 4'd3;

  // What the body of a request expands to.
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_ESC2,
    KIND_ESCU,
    KIND_UTF8,
    KIND_REPL
  } kind_e;

  // One classified request, handed from the front to the back.
  typedef struct packed {
    logic        pre_repl;
    kind_e       kind;
    logic [7:0]  esc_char;
    logic [20:0] cp;
    logic [2:0]  body_len;
    logic        text_last;
  } desc_t;

  // Upper-case hex digit of a nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = CHR_ZERO + {4'd0, v};
    end else begin
      r = CHR_UPPER_A + {4'd0, v - 4'd10};
    end
    return r;
  endfunction

  // Byte k of the replacement sequence.
  function automatic logic [7:0] repl_byte(input logic [1:0] k);
    logic [7:0] r;
    case (k)
      2'd0:    r = REPL_BYTE0;
      2'd1:    r = REPL_BYTE1;
      default: r = REPL_BYTE2;
    endcase
    return r;
  endfunction

endpackage

>>> design/u16esc_front.sv
// Front: accepts code units, pairs surrogates and classifies each unit into a request.
module u16esc_front
  import u16esc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] code_unit_i,
  input  logic        end_of_text_i,
  input  logic        queue_full_i,
  output logic        push_o,
  output desc_t       push_desc_o
);

  logic        held_valid_q, held_valid_d;
  logic [9:0]  held_bits_q, held_bits_d;
  logic        accept;
  logic        is_high, is_low, pair, new_hold;
  desc_t       desc;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_high  = code_unit_i inside {[HIGH_SURR_FIRST:HIGH_SURR_LAST]};
  assign is_low   = code_unit_i inside {[LOW_SURR_FIRST:LOW_SURR_LAST]};
  assign pair     = held_valid_q && is_low;
  assign new_hold = !pair && is_high && !end_of_text_i;

  // Classify the unit against the held surrogate.
  always_comb begin
    desc           = '0;
    desc.kind      = KIND_NONE;
    desc.text_last = end_of_text_i;
    if (pair) begin
      desc.kind     = KIND_UTF8;
      desc.cp       = SUPP_PLANE_BASE + {1'b0, held_bits_q, code_unit_i[9:0]};
      desc.body_len = 3'd4;
    end else begin
      desc.pre_repl = held_valid_q;
      case (code_unit_i)
        CODE_BSLASH: begin
          desc.kind     = KIND_ESC2;
          desc.esc_char = CHR_BSLASH;
          desc.body_len = 3'd2;
        end
        CODE_QUOTE: begin
          desc.kind     = KIND_ESC2;
          desc.esc_char = CHR_QUOTE;
          desc.body_len = 3'd2;
        end
        CODE_LF: begin
          desc.kind     = KIND_ESC2;
          desc.esc_char = CHR_N;
          desc.body_len = 3'd2;
        end
        CODE_CR: begin
          desc.kind     = KIND_ESC2;
          desc.esc_char = CHR_R;
          desc.body_len = 3'd2;
        end
        CODE_TAB: begin
          desc.kind     = KIND_ESC2;
          desc.esc_char = CHR_T;
          desc.body_len = 3'd2;
        end
        default: begin
          if (code_unit_i < CTRL_LIMIT || code_unit_i == CODE_DEL) begin
            desc.kind     = KIND_ESCU;
            desc.cp       = {5'd0, code_unit_i};
            desc.body_len = 3'd6;
          end else if (is_high) begin
            // A high surrogate at the end of the text cannot be completed.
            if (end_of_text_i) begin
              desc.kind     = KIND_REPL;
              desc.body_len = REPL_LEN[2:0];
            end
          end else if (is_low) begin
            desc.kind     = KIND_REPL;
            desc.body_len = REPL_LEN[2:0];
          end else begin
            desc.kind = KIND_UTF8;
            desc.cp   = {5'd0, code_unit_i};
            if (code_unit_i <= ONE_BYTE_MAX) begin
              desc.body_len = 3'd1;
            end else if (code_unit_i <= TWO_BYTE_MAX) begin
              desc.body_len = 3'd2;
            end else begin
              desc.body_len = 3'd3;
            end
          end
        end
      endcase
    end
  end

  assign push_desc_o = desc;
  assign push_o      = accept && (desc.pre_repl || desc.body_len != 3'd0);

  // Surrogate hold register.
  always_comb begin
    held_valid_d = held_valid_q;
    held_bits_d  = held_bits_q;
    if (accept) begin
      held_valid_d = new_hold;
      held_bits_d  = new_hold ? code_unit_i[9:0] : 10'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_bits_q  <= 10'd0;
    end else begin
      held_valid_q <= held_valid_d;
      held_bits_q  <= held_bits_d;
    end
  end

  // Nothing stays held once the text has ended.
  a_clear_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_text_i) |=> !held_valid_q)
    else $error("surrogate still held after end of text");

  // A unit that leaves nothing held while text goes on always produces bytes.
  a_push_or_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (push_o || new_hold))
    else $error("accepted unit neither queued nor held");

endmodule

>>> design/u16esc_queue.sv
// Short request queue between the classifier and the byte sequencer.
module u16esc_queue
  import u16esc_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_desc_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output desc_t head_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  desc_t         mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  assign full_o  = (count_q == CW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Request storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from an empty queue");

endmodule

>>> design/u16esc_back.sv
// Back: expands queued requests into bytes, one per cycle unless stalled.
module u16esc_back
  import u16esc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  desc_t      head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       text_last_o
);

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       run_last_q, text_last_q;
  logic [3:0] idx_q, idx_d;
  logic [3:0] total, body_idx;
  logic [2:0] q;
  logic       load, emit, fin;
  logic [7:0] body_byte, next_byte;

  assign total    = {1'b0, head_i.body_len} + (head_i.pre_repl ? REPL_LEN : 4'd0);
  assign body_idx = idx_q - (head_i.pre_repl ? REPL_LEN : 4'd0);
  assign q        = body_idx[2:0];
  assign load     = !out_valid_q || out_ready_i;
  assign emit     = !empty_i && load;
  assign fin      = (idx_q == total - 4'd1);
  assign pop_o    = emit && fin;

  // Byte of the request body at position q.
  always_comb begin
    body_byte = 8'd0;
    case (head_i.kind)
      KIND_ESC2: begin
        body_byte = (q == 3'd0) ? CHR_BSLASH : head_i.esc_char;
      end
      KIND_ESCU: begin
        case (q)
          3'd0:    body_byte = CHR_BSLASH;
          3'd1:    body_byte = CHR_U;
          3'd2:    body_byte = hex_digit(head_i.cp[15:12]);
          3'd3:    body_byte = hex_digit(head_i.cp[11:8]);
          3'd4:    body_byte = hex_digit(head_i.cp[7:4]);
          default: body_byte = hex_digit(head_i.cp[3:0]);
        endcase
      end
      KIND_UTF8: begin
        case (head_i.body_len)
          3'd1: body_byte = {1'b0, head_i.cp[6:0]};
          3'd2: begin
            body_byte = (q == 3'd0) ? (UTF8_LEAD2 | {3'd0, head_i.cp[10:6]})
                                    : (UTF8_CONT | {2'd0, head_i.cp[5:0]});
          end
          3'd3: begin
            case (q)
              3'd0:    body_byte = UTF8_LEAD3 | {4'd0, head_i.cp[15:12]};
              3'd1:    body_byte = UTF8_CONT | {2'd0, head_i.cp[11:6]};
              default: body_byte = UTF8_CONT | {2'd0, head_i.cp[5:0]};
            endcase
          end
          default: begin
            case (q)
              3'd0:    body_byte = UTF8_LEAD4 | {5'd0, head_i.cp[20:18]};
              3'd1:    body_byte = UTF8_CONT | {2'd0, head_i.cp[17:12]};
              3'd2:    body_byte = UTF8_CONT | {2'd0, head_i.cp[11:6]};
              default: body_byte = UTF8_CONT | {2'd0, head_i.cp[5:0]};
            endcase
          end
        endcase
      end
      KIND_REPL: body_byte = repl_byte(q[1:0]);
      default:   body_byte = 8'd0;
    endcase
  end

  // A replacement for an unpaired held surrogate comes before the body.
  assign next_byte = (head_i.pre_repl && idx_q < REPL_LEN) ? repl_byte(idx_q[1:0]) : body_byte;

  // Byte position within the head request.
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = emit;
    end
    if (emit) begin
      idx_d = fin ? 4'd0 : idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 4'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q  <= next_byte;
      run_last_q  <= fin;
      text_last_q <= fin && head_i.text_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;
  assign text_last_o = text_last_q;

  a_text_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && text_last_q) |-> run_last_q)
    else $error("end of text not on the last byte of a run");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (idx_q < total))
    else $error("byte position beyond the request length");

endmodule

>>> design/utf16_to_escaped_utf8.sv
// UTF-16 to escaped UTF-8 transcoder: top level joining front, queue and back.
// A unit accepted by the front is written into the queue; its first byte reaches m_axis_tvalid
// through the byte-wide output register. Throughput: one byte per cycle on the output while
// m_axis_tready is high and bytes are owed; a unit yields one to nine bytes.
// A held high surrogate yields no bytes and stays in the front's hold register.
// Reset (rst_ni low, asynchronous) empties the queue, drops any held surrogate and the output.
module utf16_to_escaped_utf8
  import u16esc_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] code_unit
  input  logic        s_axis_tlast,  // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
  output logic        m_axis_tlast,  // run_last
  output logic [0:0]  m_axis_tuser   // [0] text_last
);

  logic  push, full, pop, empty;
  desc_t push_desc, head;

  u16esc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .code_unit_i   (s_axis_tdata),
    .end_of_text_i (s_axis_tlast),
    .queue_full_i  (full),
    .push_o        (push),
    .push_desc_o   (push_desc)
  );

  u16esc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  u16esc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .run_last_o  (m_axis_tlast),
    .text_last_o (m_axis_tuser[0])
  );

endmodule

>>> sim/utf16_escape_checker.sv
// Stream checker that predicts and compares the escaped UTF-8 bytes of the transcoder.
module utf16_escape_checker
  import u16esc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] code_unit
  input  logic        s_axis_tlast,  // end_of_text
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,  // [7:0] out_byte
  input  logic        m_axis_tlast,  // run_last
  input  logic [0:0]  m_axis_tuser,  // [0] text_last
  output int          errors_o,
  output int          pending_o,
  output int          bytes_o
);

  // One escaped output byte with its two end markers.
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       text_last;
  } esc_byte_t;

  // Bytes still owed by the block, oldest first.
  esc_byte_t  owed_bytes[$];
  // Bytes produced by the code unit being predicted.
  logic [7:0] unit_bytes[$];

  // Pending high surrogate.
  logic       held_valid = 1'b0;
  logic [9:0] held_bits  = '0;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CHR_ZERO + {4'd0, nib};
    end else begin
      c = CHR_UPPER_A + {4'd0, nib} - 8'd10;
    end
    return c;
  endfunction

  function automatic void emit_replacement();
    unit_bytes.push_back(REPL_BYTE0);
    unit_bytes.push_back(REPL_BYTE1);
    unit_bytes.push_back(REPL_BYTE2);
  endfunction

  // Plain UTF-8 encoding of a code point up to U+10FFFF.
  function automatic void emit_utf8(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      unit_bytes.push_back(cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      unit_bytes.push_back(UTF8_LEAD2 | {3'd0, cp[10:6]});
      unit_bytes.push_back(UTF8_CONT | {2'd0, cp[5:0]});
    end else if (cp <= 21'hFFFF) begin
      unit_bytes.push_back(UTF8_LEAD3 | {4'd0, cp[15:12]});
      unit_bytes.push_back(UTF8_CONT | {2'd0, cp[11:6]});
      unit_bytes.push_back(UTF8_CONT | {2'd0, cp[5:0]});
    end else begin
      unit_bytes.push_back(UTF8_LEAD4 | {5'd0, cp[20:18]});
      unit_bytes.push_back(UTF8_CONT | {2'd0, cp[17:12]});
      unit_bytes.push_back(UTF8_CONT | {2'd0, cp[11:6]});
      unit_bytes.push_back(UTF8_CONT | {2'd0, cp[5:0]});
    end
  endfunction

  // Escapes or encodes one unit as if no surrogate were pending.
  function automatic void escape_fresh_unit(input logic [15:0] unit, input logic eot);
    case (unit)
      CODE_BSLASH: begin
        unit_bytes.push_back(CHR_BSLASH);
        unit_bytes.push_back(CHR_BSLASH);
      end
      CODE_QUOTE: begin
        unit_bytes.push_back(CHR_BSLASH);
        unit_bytes.push_back(CHR_QUOTE);
      end
      CODE_LF: begin
        unit_bytes.push_back(CHR_BSLASH);
        unit_bytes.push_back(CHR_N);
      end
      CODE_CR: begin
        unit_bytes.push_back(CHR_BSLASH);
        unit_bytes.push_back(CHR_R);
      end
      CODE_TAB: begin
        unit_bytes.push_back(CHR_BSLASH);
        unit_bytes.push_back(CHR_T);
      end
      default: begin
        if (unit < CTRL_LIMIT || unit == CODE_DEL) begin
          unit_bytes.push_back(CHR_BSLASH);
          unit_bytes.push_back(CHR_U);
          unit_bytes.push_back(hex_char(unit[15:12]));
          unit_bytes.push_back(hex_char(unit[11:8]));
          unit_bytes.push_back(hex_char(unit[7:4]));
          unit_bytes.push_back(hex_char(unit[3:0]));
        end else if (unit >= HIGH_SURR_FIRST && unit <= HIGH_SURR_LAST) begin
          // A high surrogate closing the text cannot be paired any more.
          if (eot) begin
            emit_replacement();
          end else begin
            held_bits  = unit[9:0];
            held_valid = 1'b1;
          end
        end else if (unit >= LOW_SURR_FIRST && unit <= LOW_SURR_LAST) begin
          emit_replacement();
        end else begin
          emit_utf8({5'd0, unit});
        end
      end
    endcase
  endfunction

  // Works out the bytes one accepted request owes and queues them.
  function automatic void predict_escaped_bytes(input logic [15:0] unit, input logic eot);
    int n;
    unit_bytes = {};
    if (held_valid) begin
      held_valid = 1'b0;
      if (unit >= LOW_SURR_FIRST && unit <= LOW_SURR_LAST) begin
        emit_utf8(SUPP_PLANE_BASE + {1'b0, held_bits, 10'd0} + {11'd0, unit[9:0]});
      end else begin
        emit_replacement();
        held_bits = '0;
        escape_fresh_unit(unit, eot);
      end
      held_bits = (held_valid) ? held_bits : '0;
    end else begin
      escape_fresh_unit(unit, eot);
    end
    n = unit_bytes.size();
    for (int k = 0; k < n; k++) begin
      owed_bytes.push_back('{unit_bytes[k], k == n - 1, (k == n - 1) && eot});
    end
  endfunction

  // Compare outgoing bytes against the oldest owed byte, then predict new requests.
  always @(posedge clk_i) begin
    esc_byte_t want;
    if (!rst_ni) begin
      owed_bytes = {};
      held_valid = 1'b0;
      held_bits  = '0;
      errors_o   = 0;
      bytes_o    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        bytes_o++;
        if (owed_bytes.size() == 0) begin
          $error("out_byte %02h arrived with nothing expected", m_axis_tdata);
          errors_o++;
        end else begin
          want = owed_bytes.pop_front();
          if (m_axis_tdata !== want.data) begin
            $error("out_byte: expected %02h, actual %02h", want.data, m_axis_tdata);
            errors_o++;
          end
          if (m_axis_tlast !== want.run_last) begin
            $error("run_last: expected %0b, actual %0b", want.run_last, m_axis_tlast);
            errors_o++;
          end
          if (m_axis_tuser[0] !== want.text_last) begin
            $error("text_last: expected %0b, actual %0b", want.text_last, m_axis_tuser[0]);
            errors_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_escaped_bytes(s_axis_tdata, s_axis_tlast);
      end
    end
    pending_o = owed_bytes.size();
  end

endmodule

>>> sim/utf16_to_escaped_utf8_test.sv
// Top of the transcoder testbench: clock, reset, stimulus, output stalls and the verdict.
module utf16_to_escaped_utf8_test;
  import u16esc_pkg::*;

  localparam int QuietLimit = 1000;
  localparam int PhaseUnits = 46;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;

  int errors;
  int pending;
  int bytes_seen;

  // Idling odds in percent, and a long output hold-off counted by the receiver.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_cycles    = 0;
  int units_sent     = 0;
  int texts_sent     = 0;

  always #5 clk_i = ~clk_i;

  utf16_to_escaped_utf8 DUT (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .m_axis_tuser
  );

  utf16_escape_checker checker_i (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .m_axis_tuser,
    .errors_o  (errors),
    .pending_o (pending),
    .bytes_o   (bytes_seen)
  );

  // Output side: random stalls, or a fixed hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Ends the run when neither side has moved for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timed out after %0d cycles without a transfer.", QuietLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  // Offers one code unit and returns right after the edge that accepts it.
  task automatic send_unit(input logic [15:0] unit, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= unit;
    s_axis_tlast  <= eot;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    units_sent++;
    if (eot) begin
      texts_sent++;
    end
  endtask

  // Drops the request line and waits until every owed byte has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Draws one non-pair unit, weighted toward the interesting classes.
  function automatic logic [15:0] random_unit();
    int pick;
    logic [15:0] u;
    pick = $urandom_range(99);
    if (pick < 22) begin
      u = 16'($urandom_range(16'h20, 16'h7E));
    end else if (pick < 32) begin
      case ($urandom_range(4))
        0:       u = CODE_BSLASH;
        1:       u = CODE_QUOTE;
        2:       u = CODE_LF;
        3:       u = CODE_CR;
        default: u = CODE_TAB;
      endcase
    end else if (pick < 40) begin
      u = ($urandom_range(7) == 0) ? CODE_DEL : 16'($urandom_range(16'h1F));
    end else if (pick < 52) begin
      u = 16'($urandom_range(16'h80, 16'h7FF));
    end else if (pick < 64) begin
      u = ($urandom_range(1) == 0) ? 16'($urandom_range(16'h800, 16'hD7FF))
                                   : 16'($urandom_range(16'hE000, 16'hFFFF));
    end else if (pick < 72) begin
      u = 16'($urandom_range(HIGH_SURR_FIRST, HIGH_SURR_LAST));
    end else if (pick < 80) begin
      u = 16'($urandom_range(LOW_SURR_FIRST, LOW_SURR_LAST));
    end else begin
      u = 16'($urandom_range(16'hFFFF));
    end
    return u;
  endfunction

  // One text of one to eight units; well-formed pairs are common, broken ones come too.
  task automatic send_random_text();
    int left;
    left = $urandom_range(1, 8);
    while (left > 0) begin
      if (left >= 2 && $urandom_range(99) < 22) begin
        send_unit(16'($urandom_range(HIGH_SURR_FIRST, HIGH_SURR_LAST)), 1'b0);
        send_unit(16'($urandom_range(LOW_SURR_FIRST, LOW_SURR_LAST)), left == 2);
        left -= 2;
      end else begin
        send_unit(random_unit(), left == 1);
        left--;
      end
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input bit long_hold);
    int start;
    start          = units_sent;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (units_sent - start < PhaseUnits) begin
      send_random_text();
      // Starve the output while input keeps coming, so the block backs up.
      if (long_hold && hold_cycles == 0 && units_sent - start >= 10
          && units_sent - start < 20) begin
        hold_cycles = 80;
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, each escape, encoding lengths and surrogate corner cases.
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0000, 1'b0);
    send_unit(CODE_BSLASH, 1'b0);
    send_unit(CODE_QUOTE, 1'b0);
    send_unit(CODE_LF, 1'b0);
    send_unit(CODE_CR, 1'b0);
    send_unit(CODE_TAB, 1'b0);
    send_unit(16'h001F, 1'b0);
    send_unit(CODE_DEL, 1'b0);
    send_unit(16'h0020, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    // Lowest and highest supplementary code points.
    send_unit(HIGH_SURR_FIRST, 1'b0);
    send_unit(LOW_SURR_FIRST, 1'b0);
    send_unit(HIGH_SURR_LAST, 1'b0);
    send_unit(LOW_SURR_LAST, 1'b0);
    // Low surrogate with nothing before it.
    send_unit(LOW_SURR_FIRST, 1'b0);
    // High surrogate followed by a plain letter, by another high, then by an escape.
    send_unit(HIGH_SURR_FIRST, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(HIGH_SURR_FIRST, 1'b0);
    send_unit(16'hD801, 1'b0);
    send_unit(CODE_LF, 1'b0);
    // High surrogate followed by a control: the longest byte run.
    send_unit(HIGH_SURR_LAST, 1'b0);
    send_unit(16'h0001, 1'b0);
    // High surrogate closing the text, then a lone low one closing the next.
    send_unit(HIGH_SURR_FIRST, 1'b1);
    send_unit(LOW_SURR_LAST, 1'b1);
    wait_drained();

    run_phase(0, 0, 1'b1);
    run_phase(58, 0, 1'b0);
    run_phase(0, 58, 1'b0);
    run_phase(8, 8, 1'b0);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d code units in %0d texts and checked %0d escaped bytes,",
             units_sent, texts_sent, bytes_seen);
    $display("under no idling, input gaps, output stalls, both, and one long output hold-off.");
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d bytes still owed.", errors, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
